>>> rtl/lbcd_pkg.sv
`default_nettype none

package lbcd_pkg;

  // Directory geometry
  localparam int SLOTS      = 16;
  localparam int AGE_BITS   = 16;
  localparam int INDEX_BITS = 24;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int TAG_W = INDEX_BITS;

  // Transaction field widths
  localparam int KIND_W   = 3;
  localparam int BLK_W    = 24;
  localparam int STATUS_W = 3;
  localparam int SLOT_FW  = 4;
  localparam int FAULT_W  = 32;

  // Configuration registers
  localparam int CS_W      = 5;
  localparam int NB_W      = 25;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;

  // Flush emits at most this many writebacks per request
  localparam int MAX_RESULTS = 16;
  localparam int FLUSH_W     = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_SIZE = 1'b0,
    CFG_NUM_BLOCKS = 1'b1
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_PIN       = 3'd2,
    KIND_UNPIN     = 3'd3,
    KIND_UNPIN_ALL = 3'd4,
    KIND_FLUSH     = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT     = 3'd0,
    STATUS_MISS    = 3'd1,
    STATUS_PASS    = 3'd2,
    STATUS_ILLEGAL = 3'd3,
    STATUS_NOT_RES = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_USED   = 2'd1,
    SLOT_PINNED = 2'd2
  } slot_state_e;

  // Targeted update applied to one cell
  typedef enum logic [2:0] {
    OP_SET_DIRTY = 3'd0,
    OP_PIN       = 3'd1,
    OP_UNPIN     = 3'd2,
    OP_CLEAN     = 3'd3,
    OP_FILL      = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_FW-1:0]  slot;
    logic                fetch_needed;
    logic                writeback_valid;
    logic [BLK_W-1:0]    writeback_block;
    logic [SLOT_FW-1:0]  writeback_slot;
    logic [FAULT_W-1:0]  fault_count;
    logic                last;
  } out_item_t;

  // Request broadcast to every cell
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] ptr;
    logic [CNT_W-1:0] n;
  } cmd_t;

  // State update strobe broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             age_all;
    logic             unpin_all;
    logic             tgt_en;
    logic [IDX_W-1:0] tgt;
    cell_op_e         op;
    logic             fill_dirty;
  } upd_t;

  // Running search record passed from cell to cell
  typedef struct packed {
    logic                hit_v;
    logic [IDX_W-1:0]    hit_idx;
    logic                first_v;
    logic [IDX_W-1:0]    first_idx;
    logic                fhi_v;
    logic [IDX_W-1:0]    fhi_idx;
    logic                flo_v;
    logic [IDX_W-1:0]    flo_idx;
    logic                vic_v;
    logic [IDX_W-1:0]    vic_idx;
    logic [AGE_BITS-1:0] vic_age;
    logic [TAG_W-1:0]    vic_tag;
    logic                vic_dirty;
    logic [1:0]          dcnt;
    logic [IDX_W-1:0]    dirty_idx;
    logic [TAG_W-1:0]    dirty_tag;
  } scan_t;

endpackage

`default_nettype wire

>>> rtl/lru_block_cache_directory_top.sv
// Flow: an accepted request is held while its search record walks the cell row
//   one slot per cycle; the resolve state then settles the result and the slot update
//   and registers the result once the output is free. A new request is taken only when idle.
// Flush: each further writeback is resolved after another full scan of the cell row.
// Reset: asynchronous, active low; all slots free and clean, pointer and miss
//   counter zero, cache_size 16, num_blocks 0. No clearing pass is needed.
`default_nettype none

module lru_block_cache_directory_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lbcd_pkg::in_item_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lbcd_pkg::out_item_t                    out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lbcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lbcd_pkg::CFG_W-1:0]        cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RES  = 3'b100
  } fsm_e;

  fsm_e                            state_q, state_d;
  logic [lbcd_pkg::IDX_W-1:0]      cnt_q, cnt_d;
  logic [lbcd_pkg::FLUSH_W-1:0]    flush_cnt_q, flush_cnt_d;
  logic [lbcd_pkg::KIND_W-1:0]     kind_q;
  logic [lbcd_pkg::BLK_W-1:0]      blk_q;
  logic [lbcd_pkg::CNT_W-1:0]      n_q;
  logic [lbcd_pkg::NB_W-1:0]       nb_q;
  logic [lbcd_pkg::IDX_W-1:0]      ptr_q, ptr_d;
  logic [lbcd_pkg::FAULT_W-1:0]    miss_q, miss_d;
  logic                            out_valid_q;
  lbcd_pkg::out_item_t             out_q;

  lbcd_pkg::cmd_t                  cmd;
  lbcd_pkg::upd_t                  upd;
  lbcd_pkg::out_item_t             res;
  lbcd_pkg::scan_t                 chain [lbcd_pkg::SLOTS+1];
  lbcd_pkg::scan_t                 tail;

  logic                            accept;
  logic                            load;
  logic                            illegal;
  logic                            fsel_v;
  logic [lbcd_pkg::IDX_W-1:0]      fsel;
  logic [lbcd_pkg::IDX_W-1:0]      sel;
  logic                            fill;
  logic [lbcd_pkg::CNT_W-1:0]      fsel_inc;
  logic [lbcd_pkg::CNT_W-1:0]      vic_inc;
  logic [lbcd_pkg::IDX_W-1:0]      fsel_wrap;
  logic [lbcd_pkg::IDX_W-1:0]      vic_wrap;
  logic [lbcd_pkg::CS_W-1:0]       cs;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_RES) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Broadcast of the current request
  assign cmd.tag = lbcd_pkg::TAG_W'(blk_q);
  assign cmd.ptr = ptr_q;
  assign cmd.n   = n_q;

  // Row of slot cells
  assign chain[0] = '0;
  for (genvar g = 0; g < lbcd_pkg::SLOTS; g++) begin : g_cell
    lbcd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (lbcd_pkg::IDX_W'(g)),
      .cmd_i  (cmd),
      .upd_i  (upd),
      .scan_i (chain[g]),
      .scan_o (chain[g+1])
    );
  end
  assign tail = chain[lbcd_pkg::SLOTS];

  // Free slot choice and pointer wrap
  assign fsel_v    = tail.fhi_v || tail.flo_v;
  assign fsel      = tail.fhi_v ? tail.fhi_idx : tail.flo_idx;
  assign fsel_inc  = lbcd_pkg::CNT_W'(fsel) + 1'b1;
  assign vic_inc   = lbcd_pkg::CNT_W'(tail.vic_idx) + 1'b1;
  assign fsel_wrap = (fsel_inc >= n_q) ? '0 : lbcd_pkg::IDX_W'(fsel_inc);
  assign vic_wrap  = (vic_inc >= n_q) ? '0 : lbcd_pkg::IDX_W'(vic_inc);

  assign illegal = (kind_q <= lbcd_pkg::KIND_UNPIN) && ({1'b0, blk_q} >= nb_q);

  // Resolve the finished search into a result and a slot update
  always_comb begin
    res      = '0;
    res.last = 1'b1;
    upd      = '0;
    upd.en   = load;
    ptr_d    = ptr_q;
    miss_d   = miss_q;
    fill     = 1'b0;
    sel      = '0;
    if (illegal) begin
      res.status = lbcd_pkg::STATUS_ILLEGAL;
    end else begin
      case (kind_q)
        lbcd_pkg::KIND_READ, lbcd_pkg::KIND_WRITE: begin
          upd.age_all = 1'b1;
          if (tail.hit_v) begin
            res.status = lbcd_pkg::STATUS_HIT;
            res.slot   = lbcd_pkg::SLOT_FW'(tail.hit_idx);
            if (kind_q == lbcd_pkg::KIND_WRITE) begin
              upd.tgt_en = 1'b1;
              upd.tgt    = tail.hit_idx;
              upd.op     = lbcd_pkg::OP_SET_DIRTY;
            end
          end else begin
            if (kind_q == lbcd_pkg::KIND_READ) begin
              miss_d = miss_q + 1'b1;
            end
            if (fsel_v) begin
              fill = 1'b1;
              sel  = fsel;
              if (fsel == ptr_q) begin
                ptr_d = fsel_wrap;
              end
            end else if (tail.vic_v) begin
              fill                = 1'b1;
              sel                 = tail.vic_idx;
              ptr_d               = vic_wrap;
              res.writeback_valid = tail.vic_dirty;
              if (tail.vic_dirty) begin
                res.writeback_block = lbcd_pkg::BLK_W'(tail.vic_tag);
                res.writeback_slot  = lbcd_pkg::SLOT_FW'(tail.vic_idx);
              end
            end else begin
              res.status = lbcd_pkg::STATUS_PASS;
            end
            if (fill) begin
              res.status       = lbcd_pkg::STATUS_MISS;
              res.slot         = lbcd_pkg::SLOT_FW'(sel);
              res.fetch_needed = (kind_q == lbcd_pkg::KIND_READ);
              upd.tgt_en       = 1'b1;
              upd.tgt          = sel;
              upd.op           = lbcd_pkg::OP_FILL;
              upd.fill_dirty   = (kind_q == lbcd_pkg::KIND_WRITE);
            end
          end
        end
        lbcd_pkg::KIND_PIN: begin
          upd.age_all = 1'b1;
          if (tail.hit_v) begin
            res.status = lbcd_pkg::STATUS_HIT;
            res.slot   = lbcd_pkg::SLOT_FW'(tail.hit_idx);
            upd.tgt_en = 1'b1;
            upd.tgt    = tail.hit_idx;
            upd.op     = lbcd_pkg::OP_PIN;
          end else begin
            res.status = lbcd_pkg::STATUS_NOT_RES;
          end
        end
        lbcd_pkg::KIND_UNPIN: begin
          if (tail.first_v) begin
            res.status = lbcd_pkg::STATUS_HIT;
            res.slot   = lbcd_pkg::SLOT_FW'(tail.first_idx);
            upd.tgt_en = 1'b1;
            upd.tgt    = tail.first_idx;
            upd.op     = lbcd_pkg::OP_UNPIN;
          end else begin
            res.status = lbcd_pkg::STATUS_NOT_RES;
          end
        end
        lbcd_pkg::KIND_UNPIN_ALL: begin
          upd.unpin_all = 1'b1;
        end
        lbcd_pkg::KIND_FLUSH: begin
          if (tail.dcnt != 2'd0) begin
            res.slot            = lbcd_pkg::SLOT_FW'(tail.dirty_idx);
            res.writeback_valid = 1'b1;
            res.writeback_block = lbcd_pkg::BLK_W'(tail.dirty_tag);
            res.writeback_slot  = lbcd_pkg::SLOT_FW'(tail.dirty_idx);
            res.last            = (tail.dcnt != 2'd2) ||
                                  (flush_cnt_q == lbcd_pkg::FLUSH_W'(lbcd_pkg::MAX_RESULTS - 1));
            upd.tgt_en          = 1'b1;
            upd.tgt             = tail.dirty_idx;
            upd.op              = lbcd_pkg::OP_CLEAN;
          end
        end
        default: ;
      endcase
    end
    res.fault_count = miss_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    flush_cnt_d = flush_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d     = S_SCAN;
          cnt_d       = '0;
          flush_cnt_d = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lbcd_pkg::IDX_W'(lbcd_pkg::SLOTS - 1)) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (load) begin
          if (res.last) begin
            state_d = S_IDLE;
          end else begin
            state_d     = S_SCAN;
            cnt_d       = '0;
            flush_cnt_d = flush_cnt_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cs = cfg_wdata_i[lbcd_pkg::CS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      flush_cnt_q <= '0;
      n_q         <= lbcd_pkg::CNT_W'(lbcd_pkg::SLOTS);
      nb_q        <= '0;
      ptr_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flush_cnt_q <= flush_cnt_d;
      if (load) begin
        ptr_q  <= ptr_d;
        miss_q <= miss_d;
      end
      // configuration writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we_i) begin
        case (cfg_index_i)
          lbcd_pkg::CFG_CACHE_SIZE: begin
            n_q   <= (32'(cs) > 32'(lbcd_pkg::SLOTS)) ?
                     lbcd_pkg::CNT_W'(lbcd_pkg::SLOTS) : lbcd_pkg::CNT_W'(cs);
            ptr_q <= '0;
          end
          lbcd_pkg::CFG_NUM_BLOCKS: nb_q <= cfg_wdata_i[lbcd_pkg::NB_W-1:0];
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_data_i.kind;
      blk_q  <= in_data_i.block_index;
    end
    if (load) begin
      out_q <= res;
    end
  end

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && (cnt_q == '0))
    else $error("accepted request did not start a fresh scan");

  a_more_results_rescan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !res.last) |=> (state_q == S_SCAN) && (cnt_q == '0))
    else $error("flush did not rescan before next writeback");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q != '0) |-> (lbcd_pkg::CNT_W'(ptr_q) < n_q))
    else $error("round-robin pointer beyond active slots");

  a_fetch_counts_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res.fetch_needed) |=> (miss_q == $past(miss_q) + 32'd1))
    else $error("read miss fill without miss count");

  a_result_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("resolved result not presented");

endmodule

`default_nettype wire

>>> rtl/lbcd_cell.sv
`default_nettype none

module lbcd_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [lbcd_pkg::IDX_W-1:0]     idx_i,
  input  wire lbcd_pkg::cmd_t                 cmd_i,
  input  wire lbcd_pkg::upd_t                 upd_i,
  input  wire lbcd_pkg::scan_t                scan_i,
  output lbcd_pkg::scan_t                     scan_o
);

  logic [lbcd_pkg::TAG_W-1:0]    tag_q, tag_d;
  lbcd_pkg::slot_state_e         st_q, st_d;
  logic [lbcd_pkg::AGE_BITS-1:0] age_q, age_d;
  logic                          dirty_q, dirty_d;
  lbcd_pkg::scan_t               scan_q, scan_d;

  logic                          en;
  logic                          valid;
  logic                          match;
  logic [lbcd_pkg::AGE_BITS-1:0] aged;

  // Local status of this slot
  assign en    = lbcd_pkg::CNT_W'(idx_i) < cmd_i.n;
  assign valid = en && (st_q != lbcd_pkg::SLOT_FREE);
  assign match = valid && (tag_q == cmd_i.tag);
  assign aged  = (age_q == lbcd_pkg::AGE_MAX) ? age_q : age_q + 1'b1;

  // Fold this slot into the running search record
  always_comb begin
    scan_d = scan_i;
    if (match) begin
      scan_d.hit_v   = 1'b1;
      scan_d.hit_idx = idx_i;
      if (!scan_i.first_v) begin
        scan_d.first_v   = 1'b1;
        scan_d.first_idx = idx_i;
      end
    end
    // free slot at or past the pointer, else before it
    if (en && (st_q == lbcd_pkg::SLOT_FREE)) begin
      if (idx_i >= cmd_i.ptr) begin
        if (!scan_i.fhi_v) begin
          scan_d.fhi_v   = 1'b1;
          scan_d.fhi_idx = idx_i;
        end
      end else if (!scan_i.flo_v) begin
        scan_d.flo_v   = 1'b1;
        scan_d.flo_idx = idx_i;
      end
    end
    // oldest unpinned slot, age as it stands after the miss ages it
    if (en && (st_q != lbcd_pkg::SLOT_PINNED) && (!scan_i.vic_v || aged > scan_i.vic_age)) begin
      scan_d.vic_v     = 1'b1;
      scan_d.vic_idx   = idx_i;
      scan_d.vic_age   = aged;
      scan_d.vic_tag   = tag_q;
      scan_d.vic_dirty = dirty_q;
    end
    // first dirty slot, and whether another follows
    if (valid && dirty_q) begin
      if (scan_i.dcnt == 2'd0) begin
        scan_d.dirty_idx = idx_i;
        scan_d.dirty_tag = tag_q;
      end
      if (scan_i.dcnt != 2'd2) begin
        scan_d.dcnt = scan_i.dcnt + 2'd1;
      end
    end
  end

  // Slot update
  always_comb begin
    tag_d   = tag_q;
    st_d    = st_q;
    age_d   = age_q;
    dirty_d = dirty_q;
    if (upd_i.en) begin
      if (upd_i.age_all && valid) begin
        age_d = match ? '0 : aged;
      end
      if (upd_i.unpin_all && en && (st_q == lbcd_pkg::SLOT_PINNED)) begin
        st_d = lbcd_pkg::SLOT_USED;
      end
      if (upd_i.tgt_en && (upd_i.tgt == idx_i)) begin
        case (upd_i.op)
          lbcd_pkg::OP_SET_DIRTY: dirty_d = 1'b1;
          lbcd_pkg::OP_PIN:       st_d    = lbcd_pkg::SLOT_PINNED;
          lbcd_pkg::OP_UNPIN:     st_d    = lbcd_pkg::SLOT_USED;
          lbcd_pkg::OP_CLEAN:     dirty_d = 1'b0;
          lbcd_pkg::OP_FILL: begin
            tag_d   = cmd_i.tag;
            st_d    = lbcd_pkg::SLOT_USED;
            age_d   = '0;
            dirty_d = upd_i.fill_dirty;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= lbcd_pkg::SLOT_FREE;
      dirty_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      dirty_q <= dirty_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    age_q  <= age_d;
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

endmodule

`default_nettype wire
